// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the record parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked on every rising clock edge outside reset.
`define PSDRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression that must never be true outside reset.
`define PSDRP_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PSDRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSDRP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/psdrp_pkg.sv =====
// Types and constants of the PSAMP drop-sample record parser.
package psdrp_pkg;

    // Token kinds
    localparam logic [3:0] KIND_PSAMP_LEN    = 4'd0;
    localparam logic [3:0] KIND_TIME         = 4'd1;
    localparam logic [3:0] KIND_SWITCH       = 4'd2;
    localparam logic [3:0] KIND_EGR_MODPORT  = 4'd3;
    localparam logic [3:0] KIND_INGRESS_PORT = 4'd4;
    localparam logic [3:0] KIND_DROP_ING     = 4'd5;
    localparam logic [3:0] KIND_DROP_MMU     = 4'd6;
    localparam logic [3:0] KIND_DROP_EGR     = 4'd7;
    localparam logic [3:0] KIND_USER_META    = 4'd8;
    localparam logic [3:0] KIND_COS          = 4'd9;
    localparam logic [3:0] KIND_SAMPLED_LEN  = 4'd10;
    localparam logic [3:0] KIND_PAYLOAD      = 4'd11;
    localparam logic [3:0] KIND_ERROR        = 4'd12;

    // Error codes carried in the value of an error token
    localparam logic [1:0] ERR_TRUNCATED = 2'd0;
    localparam logic [1:0] ERR_TEMPLATE  = 2'd1;
    localparam logic [1:0] ERR_INDICATOR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHIP_MODE = 2'd0;
    localparam logic [1:0] CFG_TID_MODE0 = 2'd1;
    localparam logic [1:0] CFG_TID_MODE1 = 2'd2;

    // Byte offsets (from the template header) of the last byte of each field
    localparam logic [4:0] POS_TEMPLATE_ID = 5'd1;
    localparam logic [4:0] POS_PSAMP_LEN   = 5'd3;
    localparam logic [4:0] POS_TIME        = 5'd11;
    localparam logic [4:0] POS_SWITCH      = 5'd15;
    localparam logic [4:0] POS_EGR_MODPORT = 5'd17;
    localparam logic [4:0] POS_INGRESS     = 5'd19;
    localparam logic [4:0] POS_DROP_0      = 5'd20;
    localparam logic [4:0] POS_DROP_1      = 5'd21;
    localparam logic [4:0] POS_USER_META   = 5'd23;
    localparam logic [4:0] POS_COS         = 5'd24;
    localparam logic [4:0] POS_INDICATOR   = 5'd25;
    localparam logic [4:0] POS_SAMPLED_LEN = 5'd27;

    // Mode 1 drop reason ranges
    localparam logic [7:0] DROP_EGR_BASE = 8'h98;
    localparam logic [7:0] DROP_MMU_BASE = 8'h90;
    localparam logic [7:0] DROP_MMU_MAX  = 8'h95;
    localparam logic [7:0] DROP_ING_MAX  = 8'h78;
    localparam logic [7:0] INDICATOR_OK  = 8'hFF;

    // Parser state between bytes
    typedef struct packed {
        logic [4:0]  pos;
        logic [55:0] acc;
        logic [15:0] remaining;
        logic        in_payload;
        logic        skipping;
    } t_state;

    // Configuration seen by the decoder
    typedef struct packed {
        logic        chip_mode;
        logic [15:0] tid_mode0;
        logic [15:0] tid_mode1;
    } t_cfg;

    // One output token
    typedef struct packed {
        logic        valid;
        logic [3:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_token;

endpackage

// ===== rtl/core/psdrp_decode.sv =====
// Per-byte decoder: next parser state and the token caused by one byte.
module psdrp_decode
    import psdrp_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output t_state     o_state,
    output t_token     o_token
);

    logic [63:0] acc_full;
    logic [15:0] rem_dec;
    logic [15:0] tid_want;
    logic        has;
    logic        bad;
    logic        done;
    logic [1:0]  err;
    logic [3:0]  kind;
    logic [63:0] val;
    logic [7:0]  b;

    assign b        = i_data_byte;
    assign acc_full = {i_state.acc, b};
    assign rem_dec  = i_state.remaining - 16'd1;
    assign tid_want = i_cfg.chip_mode ? i_cfg.tid_mode1 : i_cfg.tid_mode0;

    // Field decode by byte position
    always_comb begin
        has  = 1'b0;
        bad  = 1'b0;
        done = 1'b0;
        err  = ERR_TRUNCATED;
        kind = KIND_PSAMP_LEN;
        val  = '0;
        unique case (i_state.pos)
            POS_TEMPLATE_ID: begin
                if (acc_full[15:0] != tid_want) begin
                    bad = 1'b1;
                    err = ERR_TEMPLATE;
                end
            end
            POS_PSAMP_LEN: begin
                has = 1'b1; kind = KIND_PSAMP_LEN; val = {48'd0, acc_full[15:0]};
            end
            POS_TIME: begin
                has = 1'b1; kind = KIND_TIME; val = acc_full;
            end
            POS_SWITCH: begin
                has = 1'b1; kind = KIND_SWITCH; val = {32'd0, acc_full[31:0]};
            end
            POS_EGR_MODPORT: begin
                has = 1'b1; kind = KIND_EGR_MODPORT; val = {48'd0, acc_full[15:0]};
            end
            POS_INGRESS: begin
                has = 1'b1; kind = KIND_INGRESS_PORT; val = {48'd0, acc_full[15:0]};
            end
            POS_DROP_0: begin
                if (!i_cfg.chip_mode) begin
                    if (b != 8'd0) begin
                        has = 1'b1; kind = KIND_DROP_ING; val = {56'd0, b};
                    end
                end else if (b >= DROP_EGR_BASE) begin
                    has = 1'b1; kind = KIND_DROP_EGR; val = {56'd0, b - DROP_EGR_BASE};
                end else if (b >= DROP_MMU_BASE && b <= DROP_MMU_MAX) begin
                    has = 1'b1; kind = KIND_DROP_MMU; val = {56'd0, b - DROP_MMU_BASE};
                end else if (b <= DROP_ING_MAX) begin
                    has = 1'b1; kind = KIND_DROP_ING; val = {56'd0, b};
                end
            end
            POS_DROP_1: begin
                // mode 1 skips the metadata byte
                if (!i_cfg.chip_mode && b != 8'd0) begin
                    has = 1'b1; kind = KIND_DROP_MMU; val = {56'd0, b};
                end
            end
            POS_USER_META: begin
                has = 1'b1; kind = KIND_USER_META; val = {48'd0, acc_full[15:0]};
            end
            POS_COS: begin
                has = 1'b1; kind = KIND_COS; val = {56'd0, b};
            end
            POS_INDICATOR: begin
                if (b != INDICATOR_OK) begin
                    bad = 1'b1;
                    err = ERR_INDICATOR;
                end
            end
            POS_SAMPLED_LEN: begin
                has  = 1'b1;
                kind = KIND_SAMPLED_LEN;
                val  = {48'd0, acc_full[15:0]};
                done = (acc_full[15:0] == 16'd0);
            end
            default: begin
            end
        endcase
    end

    // State update and token selection
    always_comb begin
        o_state            = i_state;
        o_token            = '0;
        o_token.kind       = KIND_ERROR;
        if (i_state.skipping) begin
            if (i_end_of_buffer) begin
                o_state.pos      = '0;
                o_state.skipping = 1'b0;
            end
        end else if (i_state.in_payload) begin
            o_token.valid = 1'b1;
            if (rem_dec == 16'd0) begin
                o_state.pos        = '0;
                o_state.remaining  = '0;
                o_state.in_payload = 1'b0;
                o_token.kind       = KIND_PAYLOAD;
                o_token.value      = {56'd0, b};
                o_token.last       = 1'b1;
            end else if (i_end_of_buffer) begin
                o_state.pos        = '0;
                o_state.remaining  = '0;
                o_state.in_payload = 1'b0;
                o_token.kind       = KIND_ERROR;
                o_token.value      = {62'd0, ERR_TRUNCATED};
                o_token.last       = 1'b1;
            end else begin
                o_state.remaining = rem_dec;
                o_token.kind      = KIND_PAYLOAD;
                o_token.value     = {56'd0, b};
            end
        end else begin
            o_state.acc = acc_full[55:0];
            o_state.pos = i_state.pos + 5'd1;
            if (done) begin
                o_state.pos   = '0;
                o_token.valid = 1'b1;
                o_token.kind  = kind;
                o_token.value = val;
                o_token.last  = 1'b1;
            end else if (i_end_of_buffer) begin
                o_state.pos   = '0;
                o_token.valid = 1'b1;
                o_token.kind  = KIND_ERROR;
                o_token.value = {62'd0, ERR_TRUNCATED};
                o_token.last  = 1'b1;
            end else if (bad) begin
                o_state.pos      = '0;
                o_state.skipping = 1'b1;
                o_token.valid    = 1'b1;
                o_token.kind     = KIND_ERROR;
                o_token.value    = {62'd0, err};
                o_token.last     = 1'b1;
            end else if (has) begin
                o_token.valid = 1'b1;
                o_token.kind  = kind;
                o_token.value = val;
                if (i_state.pos == POS_SAMPLED_LEN) begin
                    o_state.remaining  = val[15:0];
                    o_state.in_payload = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/psamp_drop_record_parser_top.sv =====
// A token is registered and appears on the output in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the input stalls only while a token waits on a stalled output.
// The byte rate is set by the single decode stage between the parser state and the output register.
// Reset (synchronous, active low) clears the parser state but for the field accumulator, the output
// valid and the config registers; the next accepted byte is taken as the start of a record.
module psamp_drop_record_parser_top
    import psdrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // token output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_field_kind,
    output logic [63:0] o_field_value,
    output logic        o_record_last
);

`include "assert_macros.svh"

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_token      n_token;
    logic        r_out_valid;
    logic [3:0]  r_kind;
    logic [63:0] r_value;
    logic        r_last;
    logic        in_fire;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_fire    = i_in_valid & ~o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHIP_MODE: r_cfg.chip_mode <= i_cfg_wdata[0];
                CFG_TID_MODE0: r_cfg.tid_mode0 <= i_cfg_wdata;
                CFG_TID_MODE1: r_cfg.tid_mode1 <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    psdrp_decode u_decode (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_state         (n_state),
        .o_token         (n_token)
    );

    // Parser state; the field accumulator holds data only and needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos        <= '0;
            r_state.remaining  <= '0;
            r_state.in_payload <= 1'b0;
            r_state.skipping   <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= in_fire & n_token.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !o_in_stall) begin
            r_kind  <= n_token.kind;
            r_value <= n_token.value;
            r_last  <= n_token.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_kind  = r_kind;
    assign o_field_value = r_value;
    assign o_record_last = r_last;

    // Checks
    `PSDRP_ASSERT(a_err_is_last, i_clk, i_rst_n, (r_out_valid && r_kind == KIND_ERROR) |-> r_last, "error token without record_last")
    `PSDRP_NEVER(a_payload_and_skip, i_clk, i_rst_n, r_state.in_payload && r_state.skipping, "payload and skip both set")
    `PSDRP_NEVER(a_pos_range, i_clk, i_rst_n, !r_state.in_payload && r_state.pos > POS_SAMPLED_LEN, "byte position past header")
    `PSDRP_ASSERT(a_eob_restarts, i_clk, i_rst_n, (in_fire && i_end_of_buffer) |=> (r_state.pos == 5'd0 && !r_state.in_payload && !r_state.skipping), "end of buffer did not restart record")

endmodule

// ===== tb/psamp_drop_record_parser_top_tb.sv =====
// Self-checking testbench for the PSAMP drop-sample record parser: directed and random records.
`timescale 1ns / 100ps

module psamp_drop_record_parser_top_tb;
    import psdrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT          = 300000;
    localparam int unsigned DRAIN_LIMIT          = 5000;
    localparam int unsigned RAND_BYTES_PER_PHASE = 20;

    // Mode 1 drop reason bytes on and around the range boundaries
    localparam logic [7:0] DROP_EDGES [10] = '{8'h00, 8'h78, 8'h79, 8'h8F, 8'h90,
                                              8'h95, 8'h96, 8'h97, 8'h98, 8'hFF};

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_exp_token;

    // DUT ports
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_CHIP_MODE;
    logic [15:0] i_cfg_wdata     = 16'd0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_end_of_buffer = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [3:0]  o_field_kind;
    logic [63:0] o_field_value;
    logic        o_record_last;

    // Idling controls, percent of cycles
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;

    // Tokens the parser still owes, oldest first
    t_exp_token expected_tokens[$];

    // Shadow configuration
    logic        cfg_chip_mode = 1'b0;
    logic [15:0] cfg_tid_mode0 = 16'd0;
    logic [15:0] cfg_tid_mode1 = 16'd0;

    // Shadow parser state
    logic [4:0]  pr_pos        = 5'd0;
    logic [63:0] pr_acc        = 64'd0;
    logic [15:0] pr_remaining  = 16'd0;
    logic        pr_in_payload = 1'b0;
    logic        pr_skipping   = 1'b0;

    psamp_drop_record_parser_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_field_kind    (o_field_kind),
        .o_field_value   (o_field_value),
        .o_record_last   (o_record_last)
    );

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Random output back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare every output transaction with the oldest expected token
    always @(posedge i_clk) begin : token_check
        t_exp_token exp_tok;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, got kind %0d value 0x%0h last %0b",
                         $time, o_field_kind, o_field_value, o_record_last);
                err_count++;
            end else begin
                exp_tok = expected_tokens.pop_front();
                if (o_field_kind !== exp_tok.kind || o_field_value !== exp_tok.value ||
                    o_record_last !== exp_tok.last) begin
                    $display("%0t: token mismatch, expected kind %0d value 0x%0h last %0b",
                             $time, exp_tok.kind, exp_tok.value, exp_tok.last);
                    $display("%0t:                 got kind %0d value 0x%0h last %0b",
                             $time, o_field_kind, o_field_value, o_record_last);
                    err_count++;
                end
            end
        end
    end

    function automatic void restart_record();
        pr_pos        = 5'd0;
        pr_acc        = 64'd0;
        pr_remaining  = 16'd0;
        pr_in_payload = 1'b0;
        pr_skipping   = 1'b0;
    endfunction

    function automatic void expect_token(input logic [3:0] kind, input logic [63:0] value,
                                         input logic last);
        expected_tokens.push_back({kind, value, last});
    endfunction

    // Advance the shadow parser by one accepted byte
    function automatic void predict_byte(input logic [7:0] b, input logic eob);
        logic [4:0]  p;
        logic [3:0]  kind;
        logic [63:0] val;
        logic [1:0]  err;
        logic        has;
        logic        bad;
        logic        done;
        has  = 1'b0;
        bad  = 1'b0;
        done = 1'b0;
        kind = KIND_PSAMP_LEN;
        val  = 64'd0;
        err  = ERR_TRUNCATED;

        // after a fault, drop everything up to the end of the buffer
        if (pr_skipping) begin
            if (eob) restart_record();
            return;
        end

        // payload: the last byte closes the record, an early end is truncation
        if (pr_in_payload) begin
            pr_remaining = pr_remaining - 16'd1;
            if (pr_remaining == 16'd0) begin
                restart_record();
                expect_token(KIND_PAYLOAD, {56'd0, b}, 1'b1);
            end else if (eob) begin
                restart_record();
                expect_token(KIND_ERROR, {62'd0, ERR_TRUNCATED}, 1'b1);
            end else begin
                expect_token(KIND_PAYLOAD, {56'd0, b}, 1'b0);
            end
            return;
        end

        pr_acc = {pr_acc[55:0], b};
        p      = pr_pos;
        pr_pos = pr_pos + 5'd1;

        case (p)
            POS_TEMPLATE_ID: begin
                if (pr_acc[15:0] != (cfg_chip_mode ? cfg_tid_mode1 : cfg_tid_mode0)) begin
                    bad = 1'b1;
                    err = ERR_TEMPLATE;
                end
            end
            POS_PSAMP_LEN: begin
                has = 1'b1; kind = KIND_PSAMP_LEN; val = {48'd0, pr_acc[15:0]};
            end
            POS_TIME: begin
                has = 1'b1; kind = KIND_TIME; val = pr_acc;
            end
            POS_SWITCH: begin
                has = 1'b1; kind = KIND_SWITCH; val = {32'd0, pr_acc[31:0]};
            end
            POS_EGR_MODPORT: begin
                has = 1'b1; kind = KIND_EGR_MODPORT; val = {48'd0, pr_acc[15:0]};
            end
            POS_INGRESS: begin
                has = 1'b1; kind = KIND_INGRESS_PORT; val = {48'd0, pr_acc[15:0]};
            end
            POS_DROP_0: begin
                if (!cfg_chip_mode) begin
                    // zero means no ingress reason
                    if (b != 8'd0) begin
                        has = 1'b1; kind = KIND_DROP_ING; val = {56'd0, b};
                    end
                end else if (b >= DROP_EGR_BASE) begin
                    has = 1'b1; kind = KIND_DROP_EGR; val = {56'd0, b - DROP_EGR_BASE};
                end else if (b >= DROP_MMU_BASE && b <= DROP_MMU_MAX) begin
                    has = 1'b1; kind = KIND_DROP_MMU; val = {56'd0, b - DROP_MMU_BASE};
                end else if (b <= DROP_ING_MAX) begin
                    has = 1'b1; kind = KIND_DROP_ING; val = {56'd0, b};
                end
            end
            POS_DROP_1: begin
                // mode 1 ignores this byte
                if (!cfg_chip_mode && b != 8'd0) begin
                    has = 1'b1; kind = KIND_DROP_MMU; val = {56'd0, b};
                end
            end
            POS_USER_META: begin
                has = 1'b1; kind = KIND_USER_META; val = {48'd0, pr_acc[15:0]};
            end
            POS_COS: begin
                has = 1'b1; kind = KIND_COS; val = {56'd0, b};
            end
            POS_INDICATOR: begin
                if (b != INDICATOR_OK) begin
                    bad = 1'b1;
                    err = ERR_INDICATOR;
                end
            end
            POS_SAMPLED_LEN: begin
                has = 1'b1; kind = KIND_SAMPLED_LEN; val = {48'd0, pr_acc[15:0]};
                if (pr_acc[15:0] == 16'd0) begin
                    done = 1'b1;
                end else begin
                    pr_remaining  = pr_acc[15:0];
                    pr_in_payload = 1'b1;
                end
            end
            default: ;
        endcase

        // a complete record wins over end of buffer, which wins over a fault
        if (done) begin
            restart_record();
            expect_token(kind, val, 1'b1);
        end else if (eob) begin
            restart_record();
            expect_token(KIND_ERROR, {62'd0, ERR_TRUNCATED}, 1'b1);
        end else if (bad) begin
            restart_record();
            pr_skipping = 1'b1;
            expect_token(KIND_ERROR, {62'd0, err}, 1'b1);
        end else if (has) begin
            expect_token(kind, val, 1'b0);
        end
    endfunction

    // Byte image of one record: template header, data header, payload
    function automatic t_byte_q make_record(input logic [15:0] tid, input logic rand_fill,
                                            input logic [7:0] fill, input logic [7:0] drop0,
                                            input logic [7:0] drop1, input logic [7:0] ind,
                                            input logic [15:0] slen,
                                            input int unsigned n_payload);
        t_byte_q rec;
        rec.push_back(tid[15:8]);
        rec.push_back(tid[7:0]);
        // psamp length, time, switch, egress modport, ingress port
        for (int i = 0; i < 18; i++) rec.push_back(rand_fill ? 8'($urandom) : fill);
        rec.push_back(drop0);
        rec.push_back(drop1);
        // user meta, cos
        for (int i = 0; i < 3; i++) rec.push_back(rand_fill ? 8'($urandom) : fill);
        rec.push_back(ind);
        rec.push_back(slen[15:8]);
        rec.push_back(slen[7:0]);
        for (int unsigned i = 0; i < n_payload; i++)
            rec.push_back(rand_fill ? 8'($urandom) : fill);
        return rec;
    endfunction

    // One input transaction, with optional idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(b, eob);
        bytes_sent++;
    endtask

    // Send bytes 0..last_idx of a record; only the last one may end the buffer
    task automatic send_record(input t_byte_q rec, input int unsigned last_idx,
                               input logic eob_last);
        for (int unsigned i = 0; i <= last_idx; i++)
            send_byte(rec[i], (i == last_idx) ? eob_last : 1'b0);
    endtask

    // Wait for all owed tokens, then for the pipeline to empty
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_tokens.size() != 0) begin
            $display("%0t: missing tokens, expected %0d more (kind %0d value 0x%0h), got none",
                     $time, expected_tokens.size(), expected_tokens[0].kind,
                     expected_tokens[0].value);
            err_count++;
            expected_tokens.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // All three registers back to back; only while the parser is idle
    task automatic write_config(input logic mode, input logic [15:0] tid0,
                                input logic [15:0] tid1);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CHIP_MODE;
        i_cfg_wdata <= {15'($urandom), mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_TID_MODE0;
        i_cfg_wdata <= tid0;
        @(posedge i_clk);
        i_cfg_index <= CFG_TID_MODE1;
        i_cfg_wdata <= tid1;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cfg_chip_mode = mode;
        cfg_tid_mode0 = tid0;
        cfg_tid_mode1 = tid1;
    endtask

    // Reset configuration: mode 0, template 0
    task automatic test_reset_defaults();
        // absent drop reasons and an empty payload
        send_record(make_record(16'h0000, 1'b0, 8'h00, 8'h00, 8'h00, INDICATOR_OK, 16'd0, 0),
                    27, 1'b1);
        // buffer ends on the very first byte
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_template_check();
        write_config(1'b0, 16'hFFFF, 16'h0000);
        // mismatch, then bytes skipped up to end of buffer
        send_record(make_record(16'h1234, 1'b0, 8'hA5, 8'h01, 8'h02, INDICATOR_OK, 16'd0, 0),
                    3, 1'b1);
        // mismatch on the byte that ends the buffer reports truncation
        send_record(make_record(16'h0000, 1'b0, 8'h00, 8'h00, 8'h00, INDICATOR_OK, 16'd0, 0),
                    1, 1'b1);
        // all-ones fields, two payload bytes, buffer ends on the last one
        send_record(make_record(16'hFFFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, INDICATOR_OK, 16'd2, 2),
                    29, 1'b1);
        wait_drained();
    endtask

    task automatic test_indicator_check();
        // good record without end of buffer, next one follows directly
        send_record(make_record(16'hFFFF, 1'b1, 8'h00, 8'h11, 8'h22, INDICATOR_OK, 16'd1, 1),
                    28, 1'b0);
        // bad indicator, skip to end of buffer
        send_record(make_record(16'hFFFF, 1'b1, 8'h00, 8'h33, 8'h00, 8'h00, 16'd0, 0),
                    27, 1'b1);
        // bad indicator on the byte that ends the buffer
        send_record(make_record(16'hFFFF, 1'b1, 8'h00, 8'h00, 8'h44, 8'hFE, 16'd0, 0),
                    25, 1'b1);
        wait_drained();
    endtask

    task automatic test_mode1_drop_ranges();
        int unsigned picks[4] = '{1, 2, 5, 8};
        write_config(1'b1, 16'h0000, 16'hFFFF);
        // top of ingress, gap, top of mmu, base of egress
        foreach (picks[k])
            send_record(make_record(16'hFFFF, 1'b1, 8'h00, DROP_EDGES[picks[k]], 8'($urandom),
                                    INDICATOR_OK, 16'd0, 0), 27, 1'b0);
        wait_drained();
    endtask

    // One random record: mostly well formed, some faults, truncations and noise
    task automatic send_random_record();
        t_byte_q     rec;
        logic [15:0] want;
        logic [15:0] tid;
        logic [15:0] slen;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [7:0]  ind;
        logic        eob_last;
        int unsigned sel;
        int unsigned pick;
        int unsigned n_pay;
        int unsigned last_idx;
        sel = $urandom_range(99);

        // noise, then an end of buffer to realign
        if (sel < 10) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), ($urandom_range(3) == 0));
            send_byte(8'($urandom), 1'b1);
            return;
        end

        want = cfg_chip_mode ? cfg_tid_mode1 : cfg_tid_mode0;
        tid  = (sel < 20) ? (want ^ 16'($urandom_range(1, 65535))) : want;
        ind  = (sel >= 20 && sel < 30) ? 8'($urandom_range(0, 254)) : INDICATOR_OK;

        if (cfg_chip_mode)
            d0 = ($urandom_range(1) == 0) ? DROP_EDGES[$urandom_range(9)] : 8'($urandom);
        else
            d0 = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
        d1 = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);

        pick = $urandom_range(99);
        if (pick < 15) begin
            slen  = 16'd0;
            n_pay = 0;
        end else if (pick < 85) begin
            slen  = 16'($urandom_range(1, 8));
            n_pay = 32'(slen);
        end else begin
            // long payload, always cut short
            slen  = 16'($urandom_range(9, 65535));
            n_pay = $urandom_range(1, 6);
        end
        rec = make_record(tid, 1'b1, 8'h00, d0, d1, ind, slen, n_pay);

        eob_last = 1'b1;
        if (sel < 20)
            last_idx = $urandom_range(1, 4);
        else if (sel < 30)
            last_idx = $urandom_range(25, 27);
        else if (sel < 45)
            last_idx = $urandom_range(0, rec.size() - 2);
        else begin
            last_idx = rec.size() - 1;
            if (pick < 85) eob_last = 1'($urandom_range(1));
        end
        send_record(rec, last_idx, eob_last);
    endtask

    // Idling phases crossed with both chip modes
    task automatic test_random_records();
        int unsigned start;
        logic [15:0] tid0;
        logic [15:0] tid1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            case (ph % 4)
                0:       begin tid0 = 16'hFFFF; tid1 = 16'h0000; end
                1:       begin tid0 = 16'h0000; tid1 = 16'hFFFF; end
                default: begin tid0 = 16'($urandom); tid1 = 16'($urandom); end
            endcase
            write_config(1'(ph % 2), tid0, tid1);
            start = bytes_sent;
            while (bytes_sent - start < RAND_BYTES_PER_PHASE) send_random_record();
            wait_drained();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_template_check();
        test_indicator_check();
        test_mode1_drop_ranges();
        test_random_records();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/psdrp_pkg.sv
rtl/core/psdrp_decode.sv
rtl/core/psamp_drop_record_parser_top.sv
tb/psamp_drop_record_parser_top_tb.sv
